@@ rtl/rfd_pkg.sv @@
// shared constants, view codes and a helper function for the ring diagnosis table
package rfd_pkg;

	localparam int MAX_NODES = 16;
	localparam int NODE_W    = $clog2(MAX_NODES);
	localparam int CNT_W     = NODE_W + 1;
	localparam int ROW_W     = 2 * MAX_NODES;

	// view entry codes
	localparam logic [1:0] V_CORRECT = 2'd0;
	localparam logic [1:0] V_FAULTY  = 2'd1;
	localparam logic [1:0] V_UNKNOWN = 2'd2;

	// event kinds
	localparam logic [1:0] MODE_TEST     = 2'd0;
	localparam logic [1:0] MODE_FAULT    = 2'd1;
	localparam logic [1:0] MODE_RECOVERY = 2'd2;

	localparam logic [CNT_W-1:0] NODE_COUNT_RST = CNT_W'(8);
	localparam logic [CNT_W-1:0] RING_MIN       = CNT_W'(2);
	localparam logic [CNT_W-1:0] RING_CAP       = CNT_W'(MAX_NODES);

	// row of a node's view after reset: unknown, own entry correct
	function automatic logic [ROW_W-1:0] reset_row(input logic [NODE_W-1:0] t);
		logic [ROW_W-1:0] r;
		for (int i = 0; i < MAX_NODES; i++) begin
			r[2*i +: 2] = (NODE_W'(i) == t) ? V_CORRECT : V_UNKNOWN;
		end
		return r;
	endfunction

endpackage

@@ rtl/rfd_ram.sv @@
// generic single-write, single-read ram with registered read data
module rfd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/ring_fault_diagnosis_table.sv @@
// top level of the ring fault diagnosis table: event sequencer around the view memory
//
// Usage
//   Events enter on start/mode/node and are taken when start is high and busy
//   is low. A test event walks the ring from the node after the tester; each
//   tested node gives one result, marked by a one-cycle result_valid strobe,
//   and last flags the final result of the event. Fault, recovery, undefined
//   events and tests by a failed or out-of-ring tester give one skipped result.
//   The ring size register is written on cfg_valid/cfg_ready/cfg_data; ready is
//   high whenever no event is in progress.
// Sequencing
//   An accepted event goes to ST_LOAD with the tester row read at accept;
//   a skipped event gives its result there. A test walks in ST_WALK, one
//   faulty result per failed node met; a correct node has its row read and
//   gives the merged result from ST_MERGE. busy drops with the final result
//   and no new event is taken before. The view memory has one read port and
//   one row per tester, read once for the tester, once for the correct node.
// Reset
//   arst_n clears the failed flags, the row valid bits and sets the ring size
//   to 8; rows not yet written read as unknown with the own entry correct, so
//   no clearing pass is needed and events are taken right after reset.
// Results are a strobe: the receiver cannot stall the block.
module ring_fault_diagnosis_table (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [1:0]                   mode,
	input  logic [rfd_pkg::NODE_W-1:0]   node,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [rfd_pkg::CNT_W-1:0]    cfg_data,
	output logic                         result_valid,
	output logic [rfd_pkg::NODE_W-1:0]   tester,
	output logic [rfd_pkg::NODE_W-1:0]   tested,
	output logic                         tested_faulty,
	output logic                         skipped,
	output logic [rfd_pkg::ROW_W-1:0]    view_vector,
	output logic                         last
);
	import rfd_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_LOAD  = 4'b0010,
		ST_WALK  = 4'b0100,
		ST_MERGE = 4'b1000
	} state_t;

	state_t              state_q;
	logic [CNT_W-1:0]    node_count_q;
	logic [MAX_NODES-1:0] failed_q;
	logic [MAX_NODES-1:0] row_valid_q;
	logic [1:0]          mode_q;
	logic [NODE_W-1:0]   node_q;
	logic [NODE_W-1:0]   s_q;
	logic [ROW_W-1:0]    row_q;

	logic [CNT_W-1:0]    ring_n;
	logic                accept;
	logic                ram_we;
	logic [NODE_W-1:0]   ram_waddr;
	logic [ROW_W-1:0]    ram_wdata;
	logic                ram_re;
	logic [NODE_W-1:0]   ram_raddr;
	logic [ROW_W-1:0]    ram_rdata;

	logic [ROW_W-1:0]    tester_row;
	logic [ROW_W-1:0]    src_row;
	logic [ROW_W-1:0]    faulty_row;
	logic [ROW_W-1:0]    merged_row;
	logic [NODE_W-1:0]   s_next;
	logic [NODE_W-1:0]   first_s;
	logic                skip_ev;
	logic                walk_end;

	// next node round the ring
	function automatic logic [NODE_W-1:0] ring_next(input logic [NODE_W-1:0] x,
			input logic [CNT_W-1:0] n);
		logic [CNT_W-1:0] x1;
		x1 = {1'b0, x} + CNT_W'(1);
		return (x1 == n) ? '0 : x1[NODE_W-1:0];
	endfunction

	// effective ring size
	always_comb begin
		if (node_count_q < RING_MIN) begin
			ring_n = RING_MIN;
		end else if (node_count_q > RING_CAP) begin
			ring_n = RING_CAP;
		end else begin
			ring_n = node_count_q;
		end
	end

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE);
	assign accept    = start && !busy;

	// view memory, one row per tester
	rfd_ram #(
		.WIDTH(ROW_W),
		.DEPTH(MAX_NODES)
	) u_view_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// rows never written read as their reset value
	assign tester_row = row_valid_q[node_q] ? ram_rdata : reset_row(node_q);
	assign src_row    = row_valid_q[s_q] ? ram_rdata : reset_row(s_q);

	assign s_next   = ring_next(s_q, ring_n);
	assign first_s  = ring_next(node_q, ring_n);
	assign walk_end = (s_next == node_q);
	assign skip_ev  = (mode_q != MODE_TEST) || ({1'b0, node_q} >= ring_n) || failed_q[node_q];

	// tester row with the current node marked faulty
	always_comb begin
		faulty_row = row_q;
		faulty_row[2*s_q +: 2] = V_FAULTY;
	end

	// copy the source's view of nodes strictly between it and the tester
	always_comb begin
		logic btw;
		merged_row = row_q;
		for (int k = 0; k < MAX_NODES; k++) begin
			if (s_q < node_q) begin
				btw = (NODE_W'(k) > s_q) && (NODE_W'(k) < node_q);
			end else begin
				btw = (NODE_W'(k) > s_q) || (NODE_W'(k) < node_q);
			end
			if (btw && (CNT_W'(k) < ring_n)) begin
				merged_row[2*k +: 2] = src_row[2*k +: 2];
			end
		end
		merged_row[2*s_q +: 2] = V_CORRECT;
	end

	// memory port control
	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = s_q;
		ram_we    = 1'b0;
		ram_waddr = node_q;
		ram_wdata = merged_row;
		case (state_q)
			ST_IDLE: begin
				ram_re    = accept;
				ram_raddr = node;
			end
			ST_WALK: begin
				ram_re    = !failed_q[s_q];
				ram_we    = failed_q[s_q] && walk_end;
				ram_wdata = faulty_row;
			end
			ST_MERGE: begin
				ram_we = 1'b1;
			end
			default: begin
				ram_re = 1'b0;
			end
		endcase
	end

	// sequencer, flags and ring size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			node_count_q <= NODE_COUNT_RST;
			failed_q     <= '0;
			row_valid_q  <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				node_count_q <= cfg_data;
			end
			if (ram_we) begin
				row_valid_q[node_q] <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (mode == MODE_FAULT) begin
							failed_q[node] <= 1'b1;
						end else if (mode == MODE_RECOVERY) begin
							failed_q[node] <= 1'b0;
						end
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					state_q <= skip_ev ? ST_IDLE : ST_WALK;
				end
				ST_WALK: begin
					if (!failed_q[s_q]) begin
						state_q <= ST_MERGE;
					end else if (walk_end) begin
						state_q <= ST_IDLE;
					end
				end
				ST_MERGE: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// event payload and working row
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= mode;
			node_q <= node;
		end
		if (state_q == ST_LOAD) begin
			row_q <= tester_row;
			s_q   <= first_s;
		end
		if (state_q == ST_WALK && failed_q[s_q]) begin
			row_q <= faulty_row;
			s_q   <= s_next;
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= ((state_q == ST_LOAD) && skip_ev)
				|| ((state_q == ST_WALK) && failed_q[s_q])
				|| (state_q == ST_MERGE);
		end
	end

	// result beat payload
	always_ff @(posedge clk) begin
		tester <= node_q;
		case (state_q)
			ST_LOAD: begin
				tested        <= '0;
				tested_faulty <= 1'b0;
				skipped       <= 1'b1;
				view_vector   <= tester_row;
				last          <= 1'b1;
			end
			ST_WALK: begin
				tested        <= s_q;
				tested_faulty <= 1'b1;
				skipped       <= 1'b0;
				view_vector   <= faulty_row;
				last          <= walk_end;
			end
			ST_MERGE: begin
				tested        <= s_q;
				tested_faulty <= 1'b0;
				skipped       <= 1'b0;
				view_vector   <= merged_row;
				last          <= 1'b1;
			end
			default: begin
				tested        <= tested;
				tested_faulty <= tested_faulty;
				skipped       <= skipped;
				view_vector   <= view_vector;
				last          <= last;
			end
		endcase
	end

endmodule

@@ rtl/rfd_checker.sv @@
// port-level checks on the ring diagnosis table, bound to the top level
module rfd_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       start,
	input logic                       busy,
	input logic                       result_valid,
	input logic [rfd_pkg::NODE_W-1:0] tested,
	input logic                       tested_faulty,
	input logic                       skipped,
	input logic                       last
);
	import rfd_pkg::*;

	// an accepted event keeps the block busy in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("event accepted but block not busy");

	// the block goes idle only together with the final result beat
	a_idle_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> result_valid && last)
		else $error("block went idle without a final result");

	// a beat that is not final leaves the block busy
	a_more_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last |-> busy)
		else $error("non-final result while idle");

	// a skipped beat is a single, empty result
	a_skip_shape: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && skipped |-> last && !tested_faulty && (tested == '0))
		else $error("malformed skipped result");

	// finding a correct node ends the walk
	a_correct_ends: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !skipped && !tested_faulty |-> last)
		else $error("walk continued past a correct node");

endmodule

bind ring_fault_diagnosis_table rfd_checker u_rfd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.result_valid (result_valid),
	.tested       (tested),
	.tested_faulty(tested_faulty),
	.skipped      (skipped),
	.last         (last)
);
